[rtl/slse_pkg.sv]
// Shared types and codes for the sorted list engine.
// No dependencies; imported by slse_mem, slse_ctrl and sorted_list_engine_core.
package slse_pkg;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  localparam int unsigned PosWidth   = 6;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned CountWidth = 7;

  // One result beat; packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [IndexWidth-1:0] index;
    status_t               status;
  } res_t;

endpackage

[rtl/slse_mem.sv]
// Entry store of the sorted list: one write port, one read port, registered read data.
// Depends on slse_pkg (imported for house consistency).
module slse_mem
  import slse_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/slse_ctrl.sv]
// Sequencer of the sorted list: walks the entry store one entry per cycle for
// insert (shift up), remove (shift down) and search. Depends on slse_pkg.
module slse_ctrl
  import slse_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  // item side
  input  logic                   in_valid,
  output logic                   in_ready,
  input  func_t                  in_func,
  input  logic [VALUE_WIDTH-1:0] in_key,
  input  logic [PosWidth-1:0]    in_pos,
  // result side
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  // store port
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [VALUE_WIDTH-1:0] mem_wr_data,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0] mem_rd_data
);

  localparam int unsigned PW = (CW > PosWidth) ? CW : PosWidth;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS      = 6'b000010,
    S_INS_LAST = 6'b000100,
    S_REM      = 6'b001000,
    S_SRCH     = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [AW-1:0]          ptr, ptr_next;
  logic [CW-1:0]          cnt, cnt_next;
  logic [VALUE_WIDTH-1:0] key, key_next;
  logic [AW-1:0]          idx, idx_next;
  status_t                stat, stat_next;

  logic [CW-1:0] ptr_p1_c;
  logic [AW-1:0] ptr_p1;
  logic [AW-1:0] cnt_m1;

  assign ptr_p1_c = CW'(ptr) + CW'(1);
  assign ptr_p1   = ptr + AW'(1);
  assign cnt_m1   = AW'(cnt - CW'(1));

  always_comb begin
    state_next  = state;
    ptr_next    = ptr;
    cnt_next    = cnt;
    key_next    = key;
    idx_next    = idx;
    stat_next   = stat;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = key;
    mem_rd_addr = '0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_next  = in_key;
          idx_next  = '0;
          stat_next = STAT_OK;
          unique case (in_func)
            FUNC_INSERT: begin
              if (cnt == CW'(CAPACITY)) begin
                stat_next  = STAT_FULL;
                state_next = S_DONE;
              end else if (cnt == '0) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = in_key;
                cnt_next    = cnt + CW'(1);
                state_next  = S_DONE;
              end else begin
                mem_rd_addr = cnt_m1;
                ptr_next    = cnt_m1;
                state_next  = S_INS;
              end
            end
            FUNC_REMOVE: begin
              if (PW'(in_pos) >= PW'(cnt)) begin
                stat_next  = STAT_RANGE;
                state_next = S_DONE;
              end else if (PW'(in_pos) + PW'(1) == PW'(cnt)) begin
                cnt_next   = cnt - CW'(1);
                state_next = S_DONE;
              end else begin
                mem_rd_addr = AW'(in_pos) + AW'(1);
                ptr_next    = AW'(in_pos) + AW'(1);
                state_next  = S_REM;
              end
            end
            FUNC_SEARCH: begin
              if (cnt == '0) begin
                stat_next  = STAT_MISSING;
                state_next = S_DONE;
              end else begin
                ptr_next   = '0;
                state_next = S_SRCH;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_INS: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_p1;
        if (mem_rd_data >= key) begin
          // entry not less than key moves up one slot
          mem_wr_data = mem_rd_data;
          if (ptr == '0) begin
            state_next = S_INS_LAST;
          end else begin
            mem_rd_addr = ptr - AW'(1);
            ptr_next    = ptr - AW'(1);
          end
        end else begin
          mem_wr_data = key;
          idx_next    = ptr_p1;
          cnt_next    = cnt + CW'(1);
          state_next  = S_DONE;
        end
      end
      S_INS_LAST: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = key;
        idx_next    = '0;
        cnt_next    = cnt + CW'(1);
        state_next  = S_DONE;
      end
      S_REM: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr - AW'(1);
        mem_wr_data = mem_rd_data;
        if (ptr_p1_c < cnt) begin
          mem_rd_addr = ptr_p1;
          ptr_next    = ptr_p1;
        end else begin
          cnt_next   = cnt - CW'(1);
          state_next = S_DONE;
        end
      end
      S_SRCH: begin
        if (mem_rd_data == key) begin
          idx_next   = ptr;
          state_next = S_DONE;
        end else if (ptr_p1_c < cnt) begin
          mem_rd_addr = ptr_p1;
          ptr_next    = ptr_p1;
        end else begin
          stat_next  = STAT_MISSING;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    key  <= key_next;
    idx  <= idx_next;
    stat <= stat_next;
  end

  assign res.status = stat;
  assign res.index  = IndexWidth'(idx);
  assign res.count  = CountWidth'(cnt);

endmodule

[rtl/sorted_list_engine_core.sv]
// Top level of the sorted list engine: stream ports, output register, assertions.
// Depends on slse_pkg, slse_mem and slse_ctrl.
//
// Keeps an ascending list of signed values in a single-port-read, single-port-write
// store of CAPACITY words. Each input beat carries one operation and yields exactly
// one result beat. Insert walks down from the top entry, moving every entry that is
// not less than the new value up one slot, and drops the value in front of the first
// entry below it, so a new value lands ahead of existing equals. Remove shifts the
// entries above the position down by one. Search walks up from entry 0 and stops at
// the first equal entry. The store does one read and one write per cycle. Items are
// handled one at a time; a finished result sits in the output register and the next
// item is taken meanwhile. The store needs no clearing after reset: only entries
// below the count are ever used. A read whose data a walk uses never touches the
// entry written in that cycle, and every write of an item lands before the next
// item's first read, so no forwarding is needed.
// status: 0 ok, 1 full, 2 position out of range, 3 not found. index is the insert or
// search hit position (low 6 bits), else 0; count is the entry count after the item.
module sorted_list_engine_core
  import slse_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // func[1:0], value[33:2], position[39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], index[7:2], count[14:8], zero[15]
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // input unpack
  func_t                    in_func;
  logic signed [31:0]       in_value;
  logic [PosWidth-1:0]      in_pos;
  logic [VALUE_WIDTH-1:0]   in_ext;
  logic [VALUE_WIDTH-1:0]   in_key;

  assign in_func  = func_t'(s_tdata[1:0]);
  assign in_value = s_tdata[33:2];
  assign in_pos   = s_tdata[39:34];
  assign in_ext   = VALUE_WIDTH'(in_value);
  // flip the sign bit so unsigned compare gives signed order
  assign in_key   = {~in_ext[VALUE_WIDTH-1], in_ext[VALUE_WIDTH-2:0]};

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic [AW-1:0]          mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_rd_data;

  logic res_valid;
  logic res_ready;
  res_t res;

  slse_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  slse_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_func     (in_func),
    .in_key      (in_key),
    .in_pos      (in_pos),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // output register: frees the sequencer as soon as a result is parked here
  res_t out_res;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res};

`ifndef SYNTHESIS
  // sequencer never takes a beat while it holds a finished result
  a_idle_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && res_valid))
    else $error("item accepted while result pending");

  // full is only reported with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.status == STAT_FULL) |-> (out_res.count == CountWidth'(CAPACITY)))
    else $error("full status with count below capacity");

  // out-of-range and missing results carry index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.status == STAT_RANGE || out_res.status == STAT_MISSING))
    |-> (out_res.index == '0))
    else $error("nonzero index on failed item");

  // a result only follows an accepted beat or a walk in progress
  a_res_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s_tvalid || !s_tready))
    else $error("result without an item in flight");
`endif

endmodule

[test/sorted_list_engine_core_tb.sv]
// Testbench for sorted_list_engine_core: directed and random insert/remove/search beats
// checked against a queue-based mirror of the sorted list. Depends on slse_pkg and the RTL.
`timescale 1ns / 1ps

module sorted_list_engine_core_tb
  import slse_pkg::*;
;

  localparam int unsigned ListDepth   = 64;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned StallLimit  = 4000;   // cycles with no beat on either side
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned ErrPrintCap = 40;

  localparam logic signed [31:0] ValMin = 32'sh8000_0000;
  localparam logic signed [31:0] ValMax = 32'sh7fff_ffff;

  // Mirror of the sorted list plus the results still owed by the block.
  class list_tracker;
    logic signed [31:0] vals[$];
    res_t               owed[$];
    int unsigned        errors = 0;

    task report(string msg);
      if (errors < ErrPrintCap) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one accepted operation to the mirror and queue its result.
    function void note_input(func_t op, logic signed [31:0] v, logic [5:0] p);
      res_t r;
      int   i;
      r.status = STAT_OK;
      r.index  = '0;
      case (op)
        FUNC_INSERT: begin
          if (vals.size() >= ListDepth) begin
            r.status = STAT_FULL;
          end else begin
            i = 0;
            // new value goes ahead of any equal entries
            while (i < vals.size() && vals[i] < v) i++;
            vals.insert(i, v);
            r.index = i[5:0];
          end
        end
        FUNC_REMOVE: begin
          if (int'(p) >= vals.size()) r.status = STAT_RANGE;
          else vals.delete(int'(p));
        end
        FUNC_SEARCH: begin
          r.status = STAT_MISSING;
          for (i = 0; i < vals.size(); i++) begin
            if (vals[i] == v) begin
              r.status = STAT_OK;
              r.index  = i[5:0];
              break;
            end
          end
        end
        default: ;  // no-op: status ok, index 0, count unchanged
      endcase
      r.count = CountWidth'(vals.size());
      owed.push_back(r);
    endfunction

    task check_result(logic [15:0] beat);
      res_t got;
      res_t want;
      got = res_t'(beat[14:0]);
      if (owed.size() == 0) begin
        report($sformatf("result beat %h with nothing outstanding", beat));
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.index !== want.index)
        report($sformatf("index %0d, want %0d", got.index, want.index));
      if (got.count !== want.count)
        report($sformatf("count %0d, want %0d", got.count, want.count));
      if (beat[15] !== 1'b0)
        report("pad bit 15 of result beat is set");
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // func[1:0], value[33:2], position[39:34]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status[1:0], index[7:2], count[14:8], zero[15]

  list_tracker board = new();
  int unsigned sent = 0;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 47;
  int unsigned quiet_cycles = 0;

  sorted_list_engine_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check every accepted beat, then pick next cycle's ready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles where neither side moves a beat.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called right after a rising edge; returns right after the edge that took the beat.
  task automatic send_item(func_t op, logic signed [31:0] v, logic [5:0] p);
    // idle mix: sender-heavy, then receiver-heavy swapped, then none
    if (sent < RandomItems / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 47;
    end else if (sent < 2 * RandomItems / 3) begin
      send_idle_pct = 47;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p, v, op};
    do @(posedge clk); while (!s_tready);
    board.note_input(op, v, p);
    sent++;
  endtask

  // Small pool for duplicates and hits, stored entries, extremes, full range.
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return int'($urandom_range(16)) - 8;
    if (roll < 60 && board.vals.size() != 0)
      return board.vals[$urandom_range(board.vals.size() - 1)];
    if (roll < 75) begin
      case ($urandom_range(5))
        0: return ValMin;
        1: return ValMax;
        2: return 0;
        3: return -1;
        4: return ValMin + 1;
        default: return ValMax - 1;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly a live position; otherwise anywhere in the 6-bit field.
  function automatic logic [5:0] pick_position();
    if (board.vals.size() != 0 && $urandom_range(99) < 80)
      return 6'($urandom_range(board.vals.size() - 1));
    return 6'($urandom_range(63));
  endfunction

  task automatic send_random_op();
    send_item(func_t'(2'($urandom_range(3))), pick_value(), 6'($urandom_range(63)));
  endtask

  // Edges of the value range, duplicate ordering, refused removes, misses, no-op.
  task automatic run_directed();
    send_item(FUNC_SEARCH, 0, 6'd0);           // search on empty list
    send_item(FUNC_REMOVE, 0, 6'd0);           // remove on empty list
    send_item(FUNC_NOP, 0, 6'd0);
    send_item(FUNC_INSERT, 0, 6'd0);
    send_item(FUNC_INSERT, ValMax, 6'd0);
    send_item(FUNC_INSERT, ValMin, 6'd0);
    send_item(FUNC_INSERT, -1, 6'd0);
    send_item(FUNC_INSERT, 0, 6'd63);          // duplicate lands ahead of the old 0
    send_item(FUNC_SEARCH, 0, 6'd0);
    send_item(FUNC_SEARCH, ValMax, 6'd0);
    send_item(FUNC_SEARCH, ValMin, 6'd0);
    send_item(FUNC_SEARCH, 5, 6'd0);           // miss
    send_item(FUNC_REMOVE, 0, 6'd63);          // far out of range
    send_item(FUNC_REMOVE, 0, 6'd5);           // position == count
    send_item(FUNC_REMOVE, 0, 6'd4);           // last entry
    send_item(FUNC_REMOVE, 0, 6'd0);           // first entry
    send_item(FUNC_NOP, -1, 6'd63);
    send_item(FUNC_SEARCH, ValMin, 6'd63);     // removed, so a miss now
    send_item(FUNC_INSERT, ValMin, 6'd0);
    send_item(FUNC_SEARCH, -1, 6'd0);
  endtask

  task automatic run_random();
    int unsigned target;
    int unsigned roll;
    while (sent < RandomItems) begin
      case ($urandom_range(2))
        0: begin
          // fill, often all the way to full, then poke at the full list
          target = ($urandom_range(2) == 0) ? ListDepth : $urandom_range(ListDepth, 8);
          while (board.vals.size() < target && sent < RandomItems) begin
            roll = $urandom_range(99);
            if (roll < 75) send_item(FUNC_INSERT, pick_value(), 6'($urandom_range(63)));
            else if (roll < 90) send_item(FUNC_SEARCH, pick_value(), 6'($urandom_range(63)));
            else send_random_op();
          end
          if (board.vals.size() == ListDepth) begin
            repeat ($urandom_range(3, 1)) send_item(FUNC_INSERT, pick_value(), pick_position());
            send_item(FUNC_SEARCH, pick_value(), pick_position());
          end
        end
        1: begin
          // drain down to a few entries or empty
          target = $urandom_range(6);
          while (board.vals.size() > target && sent < RandomItems) begin
            roll = $urandom_range(99);
            if (roll < 70) send_item(FUNC_REMOVE, pick_value(), pick_position());
            else if (roll < 80) send_item(FUNC_REMOVE, pick_value(), 6'($urandom_range(63)));
            else send_item(FUNC_SEARCH, pick_value(), pick_position());
          end
        end
        default: begin
          repeat ($urandom_range(40, 10)) begin
            roll = $urandom_range(99);
            if (roll < 30) send_item(FUNC_INSERT, pick_value(), pick_position());
            else if (roll < 55) send_item(FUNC_REMOVE, pick_value(), pick_position());
            else if (roll < 85) send_item(FUNC_SEARCH, pick_value(), pick_position());
            else send_random_op();
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
